/* hw/rtl/dltq_pkg.sv */
package dltq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Request codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // One stored timer entry
    typedef struct packed {
        logic [7:0]  tid;
        logic [15:0] delta;
        logic [15:0] period;
    } entry_t;

    // Entry store access, one read and one write per cycle
    typedef struct packed {
        logic rd_en;
        idx_t rd_addr;
        logic wr_en;
        idx_t wr_addr;
    } mem_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK_CHK,
        S_DEL_CHK,
        S_DEL_SRD,
        S_DEL_SWR,
        S_INS_RD,
        S_INS_CHK,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/dltq_mem.sv */
module dltq_mem (
    input  logic              clk,
    input  dltq_pkg::mem_req_t req,
    input  dltq_pkg::entry_t  wr_data,
    output dltq_pkg::entry_t  rd_data
);
    import dltq_pkg::*;

    entry_t mem [QUEUE_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

/* hw/rtl/dltq_ctrl.sv */
module dltq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        req_type,
    input  logic [7:0]        task_id,
    input  logic [15:0]       delay,
    input  logic [15:0]       period,
    input  logic [3:0]        position,
    input  dltq_pkg::entry_t  rd_data,
    output dltq_pkg::mem_req_t mem_req,
    output dltq_pkg::entry_t  wr_data,
    output logic              busy,
    output logic              done,
    output logic [1:0]        status,
    output logic              due,
    output logic [7:0]        due_task,
    output logic [4:0]        slot
);
    import dltq_pkg::*;

    // Control state
    state_t      state_reg, state_next;
    cnt_t        count_reg, count_next;
    cnt_t        idx_reg, idx_next;       // walk position, insert point, delete cursor
    cnt_t        sh_reg, sh_next;         // shift cursor for insertion
    logic        merge_reg, merge_next;   // first write of a delete merges delays
    logic        reins_reg, reins_next;   // reinsert after a tick release
    logic [1:0]  status_reg, status_next;
    logic        due_reg, due_next;
    logic [7:0]  due_task_reg, due_task_next;
    logic [4:0]  slot_reg, slot_next;

    // Payload
    logic [15:0] rest_reg, rest_next;
    logic [15:0] d0_reg, d0_next;
    logic [7:0]  ins_tid_reg, ins_tid_next;
    logic [15:0] ins_per_reg, ins_per_next;

    // Helpers
    cnt_t        idx_inc;
    cnt_t        sh_dec;
    logic [16:0] merge_sum;
    logic [15:0] merge_sat;
    logic        has_next;

    assign idx_inc   = idx_reg + cnt_t'(1);
    assign sh_dec    = sh_reg - cnt_t'(1);
    assign merge_sum = {1'b0, d0_reg} + {1'b0, rd_data.delta};
    assign merge_sat = merge_sum[16] ? 16'hFFFF : merge_sum[15:0];
    assign has_next  = (idx_inc < count_reg);

    // Next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        sh_next       = sh_reg;
        merge_next    = merge_reg;
        reins_next    = reins_reg;
        status_next   = status_reg;
        due_next      = due_reg;
        due_task_next = due_task_reg;
        slot_next     = slot_reg;
        rest_next     = rest_reg;
        d0_next       = d0_reg;
        ins_tid_next  = ins_tid_reg;
        ins_per_next  = ins_per_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next   = ST_OK;
                    due_next      = 1'b0;
                    due_task_next = 8'd0;
                    slot_next     = 5'd0;
                    reins_next    = 1'b0;
                    case (req_type)
                        REQ_TICK:
                        begin
                            if (count_reg == cnt_t'(0))
                            begin
                                status_next = ST_NONE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_TICK_CHK;
                            end
                        end
                        REQ_ADD:
                        begin
                            if (count_reg == cnt_t'(QUEUE_DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ins_tid_next = task_id;
                                ins_per_next = period;
                                rest_next    = delay;
                                idx_next     = '0;
                                state_next   = S_INS_RD;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (int'(position) >= int'(count_reg))
                            begin
                                status_next = ST_NONE;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                idx_next   = cnt_t'(position);
                                state_next = S_DEL_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Head read back: count down or release
            S_TICK_CHK:
            begin
                if (rd_data.delta != 16'd0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    due_next      = 1'b1;
                    due_task_next = rd_data.tid;
                    ins_tid_next  = rd_data.tid;
                    ins_per_next  = rd_data.period;
                    rest_next     = rd_data.period;
                    reins_next    = (rd_data.period != 16'd0);
                    d0_next       = 16'd0;
                    merge_next    = 1'b1;
                    idx_next      = '0;
                    state_next    = S_DEL_SRD;
                end
            end

            // Removed entry read back: keep its delay for the merge
            S_DEL_CHK:
            begin
                d0_next    = rd_data.delta;
                merge_next = 1'b1;
                state_next = S_DEL_SRD;
            end

            S_DEL_SRD:
            begin
                if (has_next)
                begin
                    state_next = S_DEL_SWR;
                end
                else
                begin
                    count_next = count_reg - cnt_t'(1);
                    if (reins_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_DEL_SWR:
            begin
                merge_next = 1'b0;
                idx_next   = idx_inc;
                state_next = S_DEL_SRD;
            end

            // Walk the list for the insertion point
            S_INS_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = S_INS_CHK;
                end
                else
                begin
                    sh_next    = count_reg;
                    state_next = S_SH_RD;
                end
            end

            S_INS_CHK:
            begin
                if (rest_reg >= rd_data.delta)
                begin
                    rest_next  = rest_reg - rd_data.delta;
                    idx_next   = idx_inc;
                    state_next = S_INS_RD;
                end
                else
                begin
                    sh_next    = count_reg;
                    state_next = S_SH_RD;
                end
            end

            // Move later entries up by one
            S_SH_RD:
            begin
                if (sh_reg > idx_reg)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end

            S_SH_WR:
            begin
                sh_next    = sh_dec;
                state_next = S_SH_RD;
            end

            S_INS_WR:
            begin
                count_next = count_reg + cnt_t'(1);
                slot_next  = 5'(idx_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory access and strobes
    always_comb
    begin
        mem_req = '0;
        wr_data = rd_data;
        busy    = (state_reg != S_IDLE);
        done    = (state_reg == S_DONE);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = (req_type == REQ_REMOVE) ? idx_t'(position) : '0;
                end
            end
            S_TICK_CHK:
            begin
                if (rd_data.delta != 16'd0)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = '0;
                    wr_data.delta   = rd_data.delta - 16'd1;
                end
            end
            S_DEL_SRD:
            begin
                if (has_next)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_inc[IDX_W-1:0];
                end
            end
            S_DEL_SWR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg[IDX_W-1:0];
                if (merge_reg)
                begin
                    wr_data.delta = merge_sat;
                end
            end
            S_INS_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = idx_reg[IDX_W-1:0];
                end
            end
            S_SH_RD:
            begin
                if (sh_reg > idx_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = sh_dec[IDX_W-1:0];
                end
            end
            S_SH_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = sh_reg[IDX_W-1:0];
                // successor keeps only the remaining difference
                if (sh_reg == idx_inc)
                begin
                    wr_data.delta = rd_data.delta - rest_reg;
                end
            end
            S_INS_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg[IDX_W-1:0];
                wr_data.tid     = ins_tid_reg;
                wr_data.delta   = rest_reg;
                wr_data.period  = ins_per_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            sh_reg       <= '0;
            merge_reg    <= 1'b0;
            reins_reg    <= 1'b0;
            status_reg   <= ST_OK;
            due_reg      <= 1'b0;
            due_task_reg <= 8'd0;
            slot_reg     <= 5'd0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            sh_reg       <= sh_next;
            merge_reg    <= merge_next;
            reins_reg    <= reins_next;
            status_reg   <= status_next;
            due_reg      <= due_next;
            due_task_reg <= due_task_next;
            slot_reg     <= slot_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rest_reg    <= rest_next;
        d0_reg      <= d0_next;
        ins_tid_reg <= ins_tid_next;
        ins_per_reg <= ins_per_next;
    end

    assign status   = status_reg;
    assign due      = due_reg;
    assign due_task = due_task_reg;
    assign slot     = slot_reg;

endmodule

/* hw/rtl/delta_list_timer_queue.sv */
// Each request is carried out as a sequence of store reads and writes: a rejected or
// unused request goes straight to done, a tick that counts down rewrites the head, a remove
// at p shifts the later entries down and merges its delay into its successor, a release
// deletes the head and, if periodic, reinserts it; an add walks, shifts up and writes.
// A new request is taken only in idle, after done; done pulses once, receiver cannot stall it.
// Reset empties the queue (count cleared); stored entries are not cleared.
module delta_list_timer_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  task_id,
    input  logic [15:0] delay,
    input  logic [15:0] period,
    input  logic [3:0]  position,
    output logic        done,
    output logic [1:0]  status,
    output logic        due,
    output logic [7:0]  due_task,
    output logic [4:0]  slot
);
    import dltq_pkg::*;

    mem_req_t mem_req;
    entry_t   wr_data;
    entry_t   rd_data;

    // Entry store
    dltq_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Request sequencer
    dltq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .task_id  (task_id),
        .delay    (delay),
        .period   (period),
        .position (position),
        .rd_data  (rd_data),
        .mem_req  (mem_req),
        .wr_data  (wr_data),
        .busy     (busy),
        .done     (done),
        .status   (status),
        .due      (due),
        .due_task (due_task),
        .slot     (slot)
    );

endmodule
